### design/cct_pkg.sv
// ----------------------------------------------------------------------------
// Capture/compare timer package
// Shared codes, register offsets, bit positions and word types.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Item kinds carried in tuser.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_PIN   = 2'd3;

  // Register offsets.
  localparam logic [2:0] OFS_STATUS = 3'd0;
  localparam logic [2:0] OFS_CNT_HI = 3'd1;
  localparam logic [2:0] OFS_CNT_LO = 3'd2;
  localparam logic [2:0] OFS_CMP_HI = 3'd3;
  localparam logic [2:0] OFS_CMP_LO = 3'd4;
  localparam logic [2:0] OFS_CAP_HI = 3'd5;
  localparam logic [2:0] OFS_CAP_LO = 3'd6;

  // Flag bit positions in status and pending flags.
  localparam int FLG_TOF = 0;
  localparam int FLG_OCF = 1;
  localparam int FLG_ICF = 2;

  // Control bit positions.
  localparam int CTL_OLVL = 0;
  localparam int CTL_IEDG = 1;
  localparam int CTL_ETOI = 2;
  localparam int CTL_EOCI = 3;
  localparam int CTL_EICI = 4;

  // Interrupt source codes.
  localparam logic [1:0] SRC_CAPTURE  = 2'd0;
  localparam logic [1:0] SRC_COMPARE  = 2'd1;
  localparam logic [1:0] SRC_OVERFLOW = 2'd2;
  localparam logic [1:0] SRC_NONE     = 2'd3;

  localparam logic [15:0] PRESET_COUNT = 16'hfff8;
  localparam logic [15:0] TOP_COUNT    = 16'hffff;
  localparam logic [15:0] CMP_RESET    = 16'hffff;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tick_cycles;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic       pin_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic [1:0] irq_source;
    logic       compare_pin;
    logic       compare_event;
  } result_t;

endpackage

### design/cct_core.sv
// ----------------------------------------------------------------------------
// Capture/compare timer core
// Timer state registers and the single-pass update for one word.
// ----------------------------------------------------------------------------
module cct_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  cct_pkg::item_t  item,
  output cct_pkg::result_t result
);

  logic [15:0] counter_r,   counter_nxt;
  logic [15:0] cmp_val_r,   cmp_val_nxt;
  logic [15:0] cap_val_r,   cap_val_nxt;
  logic [4:0]  ctrl_r,      ctrl_nxt;
  logic [2:0]  status_r,    status_nxt;
  logic [2:0]  pending_r,   pending_nxt;
  logic [7:0]  cnt_hi_r,    cnt_hi_nxt;
  logic        cmp_due_r,   cmp_due_nxt;
  logic        ovf_due_r,   ovf_due_nxt;
  logic        pin_last_r,  pin_last_nxt;
  logic        cmp_pin_r,   cmp_pin_nxt;

  logic [16:0] sum;
  logic        wrapped;
  logic        cmp_ge;
  logic        ovf_ge;
  logic        cmp_fire;
  logic        ovf_fire;
  logic [7:0]  rd;
  logic        ici, oci, toi;

  assign sum     = {1'b0, counter_r} + {9'd0, item.tick_cycles};
  assign wrapped = sum[16];
  assign cmp_ge  = sum[15:0] >= cmp_val_r;
  assign ovf_ge  = sum[15:0] == cct_pkg::TOP_COUNT;

  // An event waiting for the next lap fires on a wrap only once the counter
  // gets to its point again; one waiting in this lap fires on any wrap.
  assign cmp_fire = wrapped ? (!cmp_due_r || cmp_ge) : (!cmp_due_r && cmp_ge);
  assign ovf_fire = wrapped ? (!ovf_due_r || ovf_ge) : (!ovf_due_r && ovf_ge);

  always_comb begin
    counter_nxt  = counter_r;
    cmp_val_nxt  = cmp_val_r;
    cap_val_nxt  = cap_val_r;
    ctrl_nxt     = ctrl_r;
    status_nxt   = status_r;
    pending_nxt  = pending_r;
    cnt_hi_nxt   = cnt_hi_r;
    cmp_due_nxt  = cmp_due_r;
    ovf_due_nxt  = ovf_due_r;
    pin_last_nxt = pin_last_r;
    cmp_pin_nxt  = cmp_pin_r;
    rd           = 8'd0;

    case (item.action)
      cct_pkg::ACT_TICK: begin
        counter_nxt = sum[15:0];
        cmp_due_nxt = (cmp_due_r == wrapped) ? cmp_ge : cmp_due_r;
        ovf_due_nxt = (ovf_due_r == wrapped) ? ovf_ge : ovf_due_r;
        if (cmp_fire) begin
          status_nxt[cct_pkg::FLG_OCF]  = 1'b1;
          pending_nxt[cct_pkg::FLG_OCF] = 1'b1;
          cmp_pin_nxt = ctrl_r[cct_pkg::CTL_OLVL];
        end
        if (ovf_fire) begin
          status_nxt[cct_pkg::FLG_TOF]  = 1'b1;
          pending_nxt[cct_pkg::FLG_TOF] = 1'b1;
        end
      end
      cct_pkg::ACT_READ: begin
        case (item.reg_offset)
          cct_pkg::OFS_STATUS: begin
            pending_nxt = 3'd0;
            rd = {status_r, ctrl_r};
          end
          cct_pkg::OFS_CNT_HI: begin
            if (!pending_r[cct_pkg::FLG_TOF]) status_nxt[cct_pkg::FLG_TOF] = 1'b0;
            rd = counter_r[15:8];
          end
          cct_pkg::OFS_CNT_LO: rd = counter_r[7:0];
          cct_pkg::OFS_CMP_HI: rd = cmp_val_r[15:8];
          cct_pkg::OFS_CMP_LO: rd = cmp_val_r[7:0];
          cct_pkg::OFS_CAP_HI: begin
            if (!pending_r[cct_pkg::FLG_ICF]) status_nxt[cct_pkg::FLG_ICF] = 1'b0;
            rd = cap_val_r[15:8];
          end
          cct_pkg::OFS_CAP_LO: rd = cap_val_r[7:0];
          default:             rd = 8'd0;
        endcase
      end
      cct_pkg::ACT_WRITE: begin
        case (item.reg_offset)
          cct_pkg::OFS_STATUS: begin
            ctrl_nxt    = item.write_data[4:0];
            pending_nxt = pending_r & status_r;
          end
          cct_pkg::OFS_CNT_HI: begin
            cnt_hi_nxt  = item.write_data;
            counter_nxt = cct_pkg::PRESET_COUNT;
            ovf_due_nxt = 1'b0;
            cmp_due_nxt = !(cmp_val_r >= cct_pkg::PRESET_COUNT);
          end
          cct_pkg::OFS_CNT_LO: begin
            counter_nxt = {cnt_hi_r, item.write_data};
            ovf_due_nxt = 1'b0;
            cmp_due_nxt = !(cmp_val_r >= {cnt_hi_r, item.write_data});
          end
          cct_pkg::OFS_CMP_HI: begin
            if (!pending_r[cct_pkg::FLG_OCF]) status_nxt[cct_pkg::FLG_OCF] = 1'b0;
            if (cmp_val_r[15:8] != item.write_data) begin
              cmp_val_nxt = {item.write_data, cmp_val_r[7:0]};
              cmp_due_nxt = !({item.write_data, cmp_val_r[7:0]} >= counter_r);
            end
          end
          cct_pkg::OFS_CMP_LO: begin
            if (!pending_r[cct_pkg::FLG_OCF]) status_nxt[cct_pkg::FLG_OCF] = 1'b0;
            if (cmp_val_r[7:0] != item.write_data) begin
              cmp_val_nxt = {cmp_val_r[15:8], item.write_data};
              cmp_due_nxt = !({cmp_val_r[15:8], item.write_data} >= counter_r);
            end
          end
          default: ;
        endcase
      end
      default: begin
        // Capture pin change: only a real level change on the selected edge
        // latches the counter.
        if (item.pin_level != pin_last_r) begin
          pin_last_nxt = item.pin_level;
          if (item.pin_level == ctrl_r[cct_pkg::CTL_IEDG]) begin
            status_nxt[cct_pkg::FLG_ICF]  = 1'b1;
            pending_nxt[cct_pkg::FLG_ICF] = 1'b1;
            cap_val_nxt = counter_r;
          end
        end
      end
    endcase
  end

  // Interrupt view uses the state after this word's update.
  assign ici = ctrl_nxt[cct_pkg::CTL_EICI] && status_nxt[cct_pkg::FLG_ICF];
  assign oci = ctrl_nxt[cct_pkg::CTL_EOCI] && status_nxt[cct_pkg::FLG_OCF];
  assign toi = ctrl_nxt[cct_pkg::CTL_ETOI] && status_nxt[cct_pkg::FLG_TOF];

  always_comb begin
    result.read_data     = rd;
    result.timer_irq     = ici || oci || toi;
    result.irq_source    = ici ? cct_pkg::SRC_CAPTURE  :
                           oci ? cct_pkg::SRC_COMPARE  :
                           toi ? cct_pkg::SRC_OVERFLOW : cct_pkg::SRC_NONE;
    result.compare_pin   = cmp_pin_nxt;
    result.compare_event = (item.action == cct_pkg::ACT_TICK) && cmp_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r  <= 16'd0;
      cmp_val_r  <= cct_pkg::CMP_RESET;
      cap_val_r  <= 16'd0;
      ctrl_r     <= 5'd0;
      status_r   <= 3'd0;
      pending_r  <= 3'd0;
      cnt_hi_r   <= 8'd0;
      cmp_due_r  <= 1'b0;
      ovf_due_r  <= 1'b0;
      pin_last_r <= 1'b0;
      cmp_pin_r  <= 1'b0;
    end else if (step) begin
      counter_r  <= counter_nxt;
      cmp_val_r  <= cmp_val_nxt;
      cap_val_r  <= cap_val_nxt;
      ctrl_r     <= ctrl_nxt;
      status_r   <= status_nxt;
      pending_r  <= pending_nxt;
      cnt_hi_r   <= cnt_hi_nxt;
      cmp_due_r  <= cmp_due_nxt;
      ovf_due_r  <= ovf_due_nxt;
      pin_last_r <= pin_last_nxt;
      cmp_pin_r  <= cmp_pin_nxt;
    end
  end

endmodule

### design/capture_compare_timer_16bit_unit.sv
// ----------------------------------------------------------------------------
// 16-bit capture/compare timer
// Free-running counter with input capture, output compare and overflow flags.
// ----------------------------------------------------------------------------
// The timer takes one word per clock while no result is stalled: a tick, a
// register read, a register write or a capture-pin change, chosen by in_tuser.
// An accepted word waits in the input register until the output register is
// free, is then processed by the core and its result registered onto the out_
// channel; while a result is stalled the input register takes at most one more
// word and then holds in_tready low until the result is taken. The rate is set
// by the core's single pass of 16-bit counter add and compare-value compare.
module capture_compare_timer_16bit_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] tick_cycles, [10:8] reg_offset, [18:11] write_data, [19] pin_level
  input  logic [23:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] timer_irq, [10:9] irq_source, [11] compare_pin,
  // [12] compare_event
  output logic [15:0] out_tdata
);

  logic             in_valid_r;
  cct_pkg::item_t   item_r;
  logic             out_valid_r;
  cct_pkg::result_t res_r;
  cct_pkg::result_t res;
  logic             advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action      <= in_tuser;
      item_r.tick_cycles <= in_tdata[7:0];
      item_r.reg_offset  <= in_tdata[10:8];
      item_r.write_data  <= in_tdata[18:11];
      item_r.pin_level   <= in_tdata[19];
    end
  end

  cct_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.compare_event, res_r.compare_pin,
                       res_r.irq_source, res_r.timer_irq, res_r.read_data};

endmodule

### design/cct_checker.sv
// ----------------------------------------------------------------------------
// Capture/compare timer port checker
// Watches the top-level ports for result consistency and output holding.
// ----------------------------------------------------------------------------
module cct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The interrupt line and its source code must agree.
  a_irq_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == (out_tdata[10:9] != cct_pkg::SRC_NONE)))
    else $error("timer_irq disagrees with irq_source");

  // A compare match only happens on a tick, which reads nothing.
  a_cmp_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[7:0] == 8'd0)
    else $error("compare event with nonzero read data");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind capture_compare_timer_16bit_unit cct_checker u_cct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
